// ----- hw/rtl/gradient_noise_turbulence_core_assert.svh -----
// Assertion macros shared by the gradient noise turbulence RTL.
// Depends on nothing; files that assert include it by name.
`ifndef GRADIENT_NOISE_TURBULENCE_CORE_ASSERT_SVH
`define GRADIENT_NOISE_TURBULENCE_CORE_ASSERT_SVH

// Same-cycle implication under synchronous active-low reset.
`define GNT_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rs) (ante) |-> (cons)) \
    else $error("gnt assertion failed");

// Next-cycle implication under synchronous active-low reset.
`define GNT_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rs) (ante) |=> (cons)) \
    else $error("gnt assertion failed");

`endif

// ----- hw/rtl/gnt_pkg.sv -----
// Package for the gradient noise turbulence core: request and result types,
// register codes, fixed-point constants and small arithmetic helpers.
// Depends on nothing.
`default_nettype none

package gnt_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam int SUM_W      = 56;
  localparam int ACC_W      = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_SCALE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT  = 1'd1;

  localparam logic [23:0] PATTERN_SCALE_RST = 24'd65536;
  localparam logic [3:0]  OCTAVE_COUNT_RST  = 4'd7;

  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [19:0] TURB_MAX = 20'd1048575;

  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
  localparam logic [31:0] SIN_C1 = 32'd1686629713;
  localparam logic [31:0] SIN_C3 = 32'd693598669;
  localparam logic [31:0] SIN_C5 = 32'd85569278;
  localparam logic [31:0] SIN_C7 = 32'd5026991;
  localparam logic [31:0] SIN_C9 = 32'd172272;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  typedef struct packed {
    logic               action;
    logic [7:0]         entry_index;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
    logic signed [15:0] grad_z;
    logic [7:0]         perm_x_value;
    logic [7:0]         perm_y_value;
    logic [7:0]         perm_z_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_req_t;

  typedef struct packed {
    logic [19:0] turbulence_value;
    logic [16:0] shade_value;
  } out_rsp_t;

  typedef struct packed {
    logic first;
    logic last;
    logic zero;
  } oct_tag_t;

  // Second half of the smoothstep: round(f2 * (3*2^16 - 2f) / 2^32).
  function automatic logic [16:0] smooth_final(input logic [31:0] f2, input logic [15:0] f);
    logic [17:0] k;
    logic [50:0] p;
    k = 18'd196608 - {1'b0, f, 1'b0};
    p = 51'(f2) * 51'(k) + 51'h8000_0000;
    return p[48:32];
  endfunction

  // One Horner step of the sine polynomial: c - round(p * t2 / 2^16).
  function automatic logic [31:0] horner_step(input logic [31:0] c, input logic [31:0] p,
                                              input logic [16:0] t2);
    logic [48:0] m;
    m = 49'(p) * 49'(t2) + 49'd32768;
    return c - m[47:16];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gnt_stream_if.sv -----
// Valid/ready stream interface carrying one request or result payload.
// Depends on nothing; the payload type is set per instance.
`default_nettype none

interface gnt_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/gnt_octave.sv -----
// Octave pipeline: table storage, lattice hashing, corner gradients and the
// weighted corner sum of one octave, seven register stages. Uses gnt_pkg.
`default_nettype none

module gnt_octave #(
  parameter int TABLE_ENTRIES = 256,
  parameter int OCT_W = 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              wr_en,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]  wr_addr,
  input  logic [47:0]                       wr_grad,
  input  logic [7:0]                        wr_perm_x,
  input  logic [7:0]                        wr_perm_y,
  input  logic [7:0]                        wr_perm_z,
  input  logic                              iss_valid,
  input  gnt_pkg::oct_tag_t                 iss_tag,
  input  logic [OCT_W-1:0]                  iss_oct,
  input  logic [31:0]                       iss_z,
  input  logic [31:0]                       iss_px,
  input  logic [31:0]                       iss_py,
  input  logic [31:0]                       iss_pz,
  output logic                              rd_busy,
  output logic                              res_valid,
  output gnt_pkg::oct_tag_t                 res_tag,
  output logic [OCT_W-1:0]                  res_oct,
  output logic [31:0]                       res_z,
  output logic signed [gnt_pkg::SUM_W-1:0]  res_sum
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int NST   = 7;

  logic [7:0]  perm_x_mem [TABLE_ENTRIES];
  logic [7:0]  perm_y_mem [TABLE_ENTRIES];
  logic [7:0]  perm_z_mem [TABLE_ENTRIES];
  logic [47:0] grad_mem [4][TABLE_ENTRIES];

  logic [NST-1:0]    v_r;
  gnt_pkg::oct_tag_t tag_r [NST];
  logic [OCT_W-1:0]  oct_r [NST];
  logic [31:0]       z_r [NST];

  logic [15:0] a_f_r [3];
  logic [31:0] a_f2_r [3];
  logic [7:0]  a_perm_r [3][2];

  logic [15:0] b_f_r [3];
  logic [16:0] b_s_r [3];
  logic [47:0] b_grad_r [8];

  logic [16:0]        c_sz_r;
  logic [16:0]        c_w2_r [4];
  logic signed [32:0] c_pr_r [8][3];

  logic [16:0]        d_w3_r [8];
  logic signed [34:0] d_dot_r [8];

  logic signed [52:0] e_prod_r [8];
  logic signed [53:0] f_sum_r [4];
  logic signed [55:0] g_sum_r;

  logic [31:0]        pos [3];
  logic [IDX_W-1:0]   cell0 [3];
  logic [IDX_W-1:0]   cell1 [3];
  logic [IDX_W-1:0]   hash [8];
  logic [16:0]        wgt [3][2];
  logic signed [16:0] offs [3][2];

  always_comb begin
    pos[0] = iss_px;
    pos[1] = iss_py;
    pos[2] = iss_pz;
    for (int i = 0; i < 3; i++) begin
      cell0[i]   = pos[i][16 +: IDX_W];
      cell1[i]   = cell0[i] + IDX_W'(1);
      wgt[i][0]  = gnt_pkg::ONE_Q16 - b_s_r[i];
      wgt[i][1]  = b_s_r[i];
      offs[i][0] = $signed({1'b0, b_f_r[i]});
      offs[i][1] = $signed({1'b0, b_f_r[i]} - gnt_pkg::ONE_Q16);
    end
    for (int k = 0; k < 8; k++) begin
      hash[k] = IDX_W'(a_perm_r[0][(k >> 2) & 1] ^ a_perm_r[1][(k >> 1) & 1]
                       ^ a_perm_r[2][k & 1]);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      perm_x_mem[wr_addr] <= wr_perm_x;
      perm_y_mem[wr_addr] <= wr_perm_y;
      perm_z_mem[wr_addr] <= wr_perm_z;
      for (int m = 0; m < 4; m++) begin
        grad_mem[m][wr_addr] <= wr_grad;
      end
    end
    if (en) begin
      a_perm_r[0][0] <= perm_x_mem[cell0[0]];
      a_perm_r[0][1] <= perm_x_mem[cell1[0]];
      a_perm_r[1][0] <= perm_y_mem[cell0[1]];
      a_perm_r[1][1] <= perm_y_mem[cell1[1]];
      a_perm_r[2][0] <= perm_z_mem[cell0[2]];
      a_perm_r[2][1] <= perm_z_mem[cell1[2]];
      for (int k = 0; k < 8; k++) begin
        b_grad_r[k] <= grad_mem[k >> 1][hash[k]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], iss_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= iss_tag;
      oct_r[0] <= iss_oct;
      z_r[0]   <= iss_z;
      for (int i = 1; i < NST; i++) begin
        tag_r[i] <= tag_r[i-1];
        oct_r[i] <= oct_r[i-1];
        z_r[i]   <= z_r[i-1];
      end
      for (int i = 0; i < 3; i++) begin
        a_f_r[i]  <= pos[i][15:0];
        a_f2_r[i] <= 32'(pos[i][15:0]) * 32'(pos[i][15:0]);
        b_f_r[i]  <= a_f_r[i];
        b_s_r[i]  <= gnt_pkg::smooth_final(a_f2_r[i], a_f_r[i]);
      end
      c_sz_r <= b_s_r[2];
      for (int j = 0; j < 4; j++) begin
        c_w2_r[j] <= 17'((34'(wgt[0][(j >> 1) & 1]) * 34'(wgt[1][j & 1]) + 34'd32768) >> 16);
      end
      for (int k = 0; k < 8; k++) begin
        for (int i = 0; i < 3; i++) begin
          c_pr_r[k][i] <= $signed(b_grad_r[k][47-16*i -: 16]) * offs[i][(k >> (2-i)) & 1];
        end
      end
      for (int k = 0; k < 8; k++) begin
        d_w3_r[k]  <= 17'((34'(c_w2_r[k >> 1])
                          * 34'(((k & 1) == 1) ? c_sz_r : gnt_pkg::ONE_Q16 - c_sz_r)
                          + 34'd32768) >> 16);
        d_dot_r[k] <= c_pr_r[k][0] + c_pr_r[k][1] + c_pr_r[k][2];
        e_prod_r[k] <= $signed({1'b0, d_w3_r[k]}) * d_dot_r[k];
      end
      for (int j = 0; j < 4; j++) begin
        f_sum_r[j] <= e_prod_r[2*j] + e_prod_r[2*j+1];
      end
      g_sum_r <= f_sum_r[0] + f_sum_r[1] + f_sum_r[2] + f_sum_r[3];
    end
  end

  assign rd_busy   = v_r[0];
  assign res_valid = v_r[NST-1];
  assign res_tag   = tag_r[NST-1];
  assign res_oct   = oct_r[NST-1];
  assign res_z     = z_r[NST-1];
  assign res_sum   = g_sum_r;

endmodule

`default_nettype wire

// ----- hw/rtl/gnt_shade.sv -----
// Shade pipeline: angle from z and turbulence, phase in turns, folded
// quarter-wave sine polynomial and grey level, twelve stages. Uses gnt_pkg.
`default_nettype none

module gnt_shade (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [19:0] in_turb,
  input  logic [31:0] in_z,
  input  logic [23:0] scale,
  output logic        out_valid,
  output logic [19:0] out_turb,
  output logic [16:0] out_shade
);

  logic [11:0]        v_r;
  logic [19:0]        turb_r [12];
  logic signed [56:0] s1_p_r;
  logic [23:0]        s1_t10_r;
  logic [63:0]        s2_ang_r;
  logic [61:0]        s3_lo_r;
  logic [31:0]        s3_hi_r;
  logic [31:0]        s4_ph_r;
  logic [16:0]        tt_r [6];
  logic               neg_r [7];
  logic [16:0]        t2_r [4];
  logic [31:0]        p_r [4];
  logic [18:0]        r_r;
  logic [16:0]        shade_r;

  logic [61:0] hi_full;
  logic [30:0] tsum;
  logic [16:0] tq;
  logic [16:0] sat;
  logic [17:0] shade_sum;

  always_comb begin
    hi_full   = 62'(s2_ang_r[63:32]) * 62'(gnt_pkg::INV_TWO_PI_Q32);
    tsum      = 31'(s4_ph_r[29:0]) + 31'h2000;
    tq        = tsum[30:14];
    sat       = (r_r > 19'(gnt_pkg::ONE_Q16)) ? gnt_pkg::ONE_Q16 : r_r[16:0];
    shade_sum = neg_r[6] ? 18'(gnt_pkg::ONE_Q16) - 18'(sat) + 18'd1
                         : 18'(gnt_pkg::ONE_Q16) + 18'(sat) + 18'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[10:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      turb_r[0] <= in_turb;
      for (int i = 1; i < 12; i++) begin
        turb_r[i] <= turb_r[i-1];
      end
      s1_p_r   <= $signed(in_z) * $signed({1'b0, scale});
      s1_t10_r <= 24'(in_turb) * 24'd10;
      s2_ang_r <= {{7{s1_p_r[56]}}, s1_p_r} + {24'd0, s1_t10_r, 16'd0};
      s3_lo_r  <= 62'(s2_ang_r[31:0]) * 62'(gnt_pkg::INV_TWO_PI_Q32);
      s3_hi_r  <= hi_full[31:0];
      s4_ph_r  <= {2'b0, s3_lo_r[61:32]} + s3_hi_r;
      tt_r[0]  <= s4_ph_r[30] ? gnt_pkg::ONE_Q16 - tq : tq;
      neg_r[0] <= s4_ph_r[31];
      for (int i = 1; i < 6; i++) begin
        tt_r[i] <= tt_r[i-1];
      end
      for (int i = 1; i < 7; i++) begin
        neg_r[i] <= neg_r[i-1];
      end
      t2_r[0] <= 17'((34'(tt_r[0]) * 34'(tt_r[0]) + 34'd32768) >> 16);
      for (int i = 1; i < 4; i++) begin
        t2_r[i] <= t2_r[i-1];
      end
      p_r[0]  <= gnt_pkg::horner_step(gnt_pkg::SIN_C7, gnt_pkg::SIN_C9, t2_r[0]);
      p_r[1]  <= gnt_pkg::horner_step(gnt_pkg::SIN_C5, p_r[0], t2_r[1]);
      p_r[2]  <= gnt_pkg::horner_step(gnt_pkg::SIN_C3, p_r[1], t2_r[2]);
      p_r[3]  <= gnt_pkg::horner_step(gnt_pkg::SIN_C1, p_r[2], t2_r[3]);
      r_r     <= 19'((49'(tt_r[5]) * 49'(p_r[3]) + 49'h2000_0000) >> 30);
      shade_r <= shade_sum[17:1];
    end
  end

  assign out_valid = v_r[11];
  assign out_turb  = turb_r[11];
  assign out_shade = shade_r;

endmodule

`default_nettype wire

// ----- hw/rtl/gradient_noise_turbulence_core.sv -----
// Top level of the gradient noise turbulence core: configuration registers,
// octave issue, octave accumulation and the output skid. Uses gnt_pkg,
// gnt_stream_if, gnt_octave, gnt_shade and the assertion macro header.
//
//   Channel  Direction  Handshake          Payload
//   in_ch    sink       valid/ready        gnt_pkg::in_req_t (sample or load)
//   out_ch   source     valid/ready        gnt_pkg::out_rsp_t (one per sample)
//   cfg_*    sink       cfg_we only        cfg_index, cfg_data
//
// A sample request holds the octave issue stage for its N octaves, N being
// octave_count limited to MAX_OCTAVES and at least one; the next sample is taken
// in the cycle its last octave issues. A load waits while a sample issues and
// while the first octave stage is still busy (rd_busy). Synchronous reset clears
// the valid bits and sets the configuration registers to their defaults; tables
// are undefined until loaded. A stalled result moves into a skid register, and
// the pipeline freezes only while that is full.
`default_nettype none

`include "gradient_noise_turbulence_core_assert.svh"

module gradient_noise_turbulence_core #(
  parameter int TABLE_ENTRIES = 256,
  parameter int MAX_OCTAVES = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  gnt_stream_if.sink                       in_ch,
  gnt_stream_if.source                     out_ch,
  input  logic                             cfg_we,
  input  logic [gnt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gnt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int OCT_W = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;

  logic [23:0] scale_r;
  logic [3:0]  octc_r;

  logic             en;
  logic             in_acc;
  logic             load_acc;
  logic             iss_v_r;
  logic             iss_first_r;
  logic             iss_zero_r;
  logic [OCT_W-1:0] oct_r;
  logic [OCT_W-1:0] nm1_r;
  logic [31:0]      px_r;
  logic [31:0]      py_r;
  logic [31:0]      pz_r;
  logic [31:0]      z0_r;
  logic             iss_last;
  logic [4:0]       cnt_ext;
  logic [4:0]       eff;
  logic             cnt_zero;
  logic [OCT_W-1:0] nm1_nxt;
  gnt_pkg::oct_tag_t iss_tag;

  logic                             rd_busy;
  logic                             res_v;
  gnt_pkg::oct_tag_t                res_tag;
  logic [OCT_W-1:0]                 res_oct;
  logic [31:0]                      res_z;
  logic signed [gnt_pkg::SUM_W-1:0] res_sum;

  logic [5:0]         sh_m1;
  logic signed [56:0] rnd;
  logic signed [56:0] shifted;

  logic                             h_v_r;
  gnt_pkg::oct_tag_t                h_tag_r;
  logic [31:0]                      h_z_r;
  logic signed [gnt_pkg::ACC_W-1:0] h_val_r;
  logic signed [gnt_pkg::ACC_W-1:0] acc_r;
  logic signed [gnt_pkg::ACC_W-1:0] acc_nxt;
  logic                             i_v_r;
  logic [31:0]                      i_z_r;
  logic [gnt_pkg::ACC_W-1:0]        mag;
  logic                             j_v_r;
  logic [19:0]                      j_turb_r;
  logic [31:0]                      j_z_r;

  logic               sh_v;
  logic [19:0]        sh_turb;
  logic [16:0]        sh_shade;
  gnt_pkg::out_rsp_t  sh_rsp;
  logic               out_v_r;
  gnt_pkg::out_rsp_t  out_q_r;
  logic               skid_v_r;
  gnt_pkg::out_rsp_t  skid_q_r;
  logic               out_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= gnt_pkg::PATTERN_SCALE_RST;
      octc_r  <= gnt_pkg::OCTAVE_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gnt_pkg::CFG_PATTERN_SCALE: scale_r <= cfg_data;
        gnt_pkg::CFG_OCTAVE_COUNT:  octc_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign en       = !skid_v_r;
  assign iss_last = (oct_r == nm1_r);
  assign cnt_ext  = {1'b0, octc_r};
  assign eff      = (cnt_ext > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) : cnt_ext;
  assign cnt_zero = (octc_r == 4'd0);
  assign nm1_nxt  = cnt_zero ? '0 : OCT_W'(eff - 5'd1);

  assign in_ch.ready = en && (!iss_v_r || iss_last)
                       && (in_ch.payload.action == gnt_pkg::ACT_SAMPLE
                           || (!iss_v_r && !rd_busy));
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign load_acc = in_acc && in_ch.payload.action == gnt_pkg::ACT_LOAD;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_v_r <= 1'b0;
    end else if (en) begin
      if (in_acc && in_ch.payload.action == gnt_pkg::ACT_SAMPLE) begin
        iss_v_r <= 1'b1;
      end else if (iss_v_r && iss_last) begin
        iss_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (in_acc && in_ch.payload.action == gnt_pkg::ACT_SAMPLE) begin
        px_r        <= in_ch.payload.pos_x;
        py_r        <= in_ch.payload.pos_y;
        pz_r        <= in_ch.payload.pos_z;
        z0_r        <= in_ch.payload.pos_z;
        oct_r       <= '0;
        nm1_r       <= nm1_nxt;
        iss_zero_r  <= cnt_zero;
        iss_first_r <= 1'b1;
      end else if (iss_v_r) begin
        px_r        <= {px_r[30:0], 1'b0};
        py_r        <= {py_r[30:0], 1'b0};
        pz_r        <= {pz_r[30:0], 1'b0};
        oct_r       <= oct_r + OCT_W'(1);
        iss_first_r <= 1'b0;
      end
    end
  end

  assign iss_tag = '{first: iss_first_r, last: iss_last, zero: iss_zero_r};

  gnt_octave #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .OCT_W         (OCT_W)
  ) u_octave (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .wr_en     (load_acc),
    .wr_addr   (IDX_W'(in_ch.payload.entry_index)),
    .wr_grad   ({in_ch.payload.grad_x, in_ch.payload.grad_y, in_ch.payload.grad_z}),
    .wr_perm_x (in_ch.payload.perm_x_value),
    .wr_perm_y (in_ch.payload.perm_y_value),
    .wr_perm_z (in_ch.payload.perm_z_value),
    .iss_valid (iss_v_r),
    .iss_tag   (iss_tag),
    .iss_oct   (oct_r),
    .iss_z     (z0_r),
    .iss_px    (px_r),
    .iss_py    (py_r),
    .iss_pz    (pz_r),
    .rd_busy   (rd_busy),
    .res_valid (res_v),
    .res_tag   (res_tag),
    .res_oct   (res_oct),
    .res_z     (res_z),
    .res_sum   (res_sum)
  );

  // Octave value: round half up of the corner sum over 2^(30+octave).
  always_comb begin
    sh_m1   = 6'd29 + 6'(res_oct);
    rnd     = {res_sum[gnt_pkg::SUM_W-1], res_sum} + (57'sd1 <<< sh_m1);
    shifted = rnd >>> (sh_m1 + 6'd1);
    acc_nxt = (h_tag_r.first ? '0 : acc_r) + h_val_r;
    mag     = acc_r[gnt_pkg::ACC_W-1] ? gnt_pkg::ACC_W'(-acc_r) : gnt_pkg::ACC_W'(acc_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
      i_v_r <= 1'b0;
      j_v_r <= 1'b0;
    end else if (en) begin
      h_v_r <= res_v;
      i_v_r <= h_v_r && h_tag_r.last;
      j_v_r <= i_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_tag_r  <= res_tag;
      h_z_r    <= res_z;
      h_val_r  <= res_tag.zero ? '0 : gnt_pkg::ACC_W'(shifted);
      if (h_v_r) begin
        acc_r <= acc_nxt;
      end
      i_z_r    <= h_z_r;
      j_turb_r <= (mag > gnt_pkg::ACC_W'(gnt_pkg::TURB_MAX)) ? gnt_pkg::TURB_MAX : mag[19:0];
      j_z_r    <= i_z_r;
    end
  end

  gnt_shade u_shade (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (j_v_r),
    .in_turb   (j_turb_r),
    .in_z      (j_z_r),
    .scale     (scale_r),
    .out_valid (sh_v),
    .out_turb  (sh_turb),
    .out_shade (sh_shade)
  );

  assign sh_rsp   = '{turbulence_value: sh_turb, shade_value: sh_shade};
  assign out_take = out_v_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (en && sh_v) begin
      if (!out_v_r || out_take) begin
        out_v_r <= 1'b1;
        out_q_r <= sh_rsp;
      end else begin
        skid_v_r <= 1'b1;
        skid_q_r <= sh_rsp;
      end
    end else if (out_take) begin
      if (skid_v_r) begin
        out_q_r  <= skid_q_r;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid   = out_v_r;
  assign out_ch.payload = out_q_r;

  `GNT_ASSERT_IMP(a_skid_needs_out, clk, rst_n, skid_v_r, out_v_r)
  `GNT_ASSERT_IMP(a_load_tables_quiet, clk, rst_n, load_acc, !iss_v_r && !rd_busy)
  `GNT_ASSERT_NXT(a_last_octave_ends, clk, rst_n, en && iss_v_r && iss_last && !in_acc, !iss_v_r)

endmodule

`default_nettype wire

// ----- bench/gnt_turbulence_checker.sv -----
// Checker for the gradient noise turbulence core: watches the request, result and
// register ports, predicts every result and compares it field by field.
// Depends on gnt_pkg.
module gnt_turbulence_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  gnt_pkg::in_req_t  in_payload,
  input  logic              out_valid,
  input  logic              out_ready,
  input  gnt_pkg::out_rsp_t out_payload,
  input  logic              cfg_we,
  input  logic [gnt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gnt_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                fail_count,
  output int                pending_count
);

  logic signed [15:0] grad_tab [256][3];
  logic [7:0] perm_x_tab [256];
  logic [7:0] perm_y_tab [256];
  logic [7:0] perm_z_tab [256];
  logic [23:0] scale_reg;
  logic [3:0]  octaves_reg;
  gnt_pkg::out_rsp_t shade_queue [$];

  function automatic longint smooth_weight(input longint f);
    bit [63:0] t;
    t = f;
    return longint'((t * t * (64'd196608 - 64'd2 * t) + 64'h8000_0000) >> 32);
  endfunction

  function automatic longint lattice_sum(input bit [31:0] px, input bit [31:0] py,
                                         input bit [31:0] pz);
    longint fx, fy, fz, sx, sy, sz, ox, oy, oz, wx, wy, wz, w2, w3, dot, sum;
    bit [7:0] ix, iy, iz, g;
    fx = px[15:0];
    fy = py[15:0];
    fz = pz[15:0];
    sx = smooth_weight(fx);
    sy = smooth_weight(fy);
    sz = smooth_weight(fz);
    sum = 0;
    for (int a = 0; a < 2; a++)
      for (int b = 0; b < 2; b++)
        for (int c = 0; c < 2; c++) begin
          ix = px[23:16] + 8'(a);
          iy = py[23:16] + 8'(b);
          iz = pz[23:16] + 8'(c);
          g = perm_x_tab[ix] ^ perm_y_tab[iy] ^ perm_z_tab[iz];
          ox = a ? fx - 65536 : fx;
          oy = b ? fy - 65536 : fy;
          oz = c ? fz - 65536 : fz;
          dot = longint'(grad_tab[g][0]) * ox + longint'(grad_tab[g][1]) * oy
              + longint'(grad_tab[g][2]) * oz;
          wx = a ? sx : 65536 - sx;
          wy = b ? sy : 65536 - sy;
          wz = c ? sz : 65536 - sz;
          w2 = (wx * wy + 32768) >>> 16;
          w3 = (w2 * wz + 32768) >>> 16;
          sum += w3 * dot;
        end
    return sum;
  endfunction

  function automatic longint quarter_wave(input longint t);
    longint t2, p, r;
    t2 = (t * t + 32768) >>> 16;
    p = gnt_pkg::SIN_C9;
    p = longint'(gnt_pkg::SIN_C7) - ((p * t2 + 32768) >>> 16);
    p = longint'(gnt_pkg::SIN_C5) - ((p * t2 + 32768) >>> 16);
    p = longint'(gnt_pkg::SIN_C3) - ((p * t2 + 32768) >>> 16);
    p = longint'(gnt_pkg::SIN_C1) - ((p * t2 + 32768) >>> 16);
    r = (t * p + (longint'(1) << 29)) >>> 30;
    return (r > 65536) ? 65536 : r;
  endfunction

  function automatic gnt_pkg::out_rsp_t marble_sample(input gnt_pkg::in_req_t r);
    gnt_pkg::out_rsp_t res;
    longint acc, raw, t, s, zs;
    int n;
    bit [63:0] angle, prod;
    bit [31:0] phase;
    n = (octaves_reg > 8) ? 8 : octaves_reg;
    acc = 0;
    for (int o = 0; o < n; o++) begin
      raw = lattice_sum(32'(r.pos_x << o), 32'(r.pos_y << o), 32'(r.pos_z << o));
      acc += (raw + (longint'(1) << (29 + o))) >>> (30 + o);
    end
    if (acc < 0) acc = -acc;
    res.turbulence_value = (acc > 1048575) ? 20'hFFFFF : acc[19:0];
    zs = longint'(r.pos_z);
    angle = 64'(zs) * 64'(scale_reg) + ((64'(res.turbulence_value) * 10) << 16);
    prod = angle * 64'd683565276;
    phase = prod[63:32];
    t = ((phase & 32'h3FFF_FFFF) + 32'h2000) >> 14;
    s = quarter_wave(phase[30] ? 65536 - t : t);
    if (phase[31]) s = -s;
    s = (65536 + s + 1) >>> 1;
    res.shade_value = s[16:0];
    return res;
  endfunction

  always @(posedge clk) begin
    gnt_pkg::out_rsp_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      scale_reg <= gnt_pkg::PATTERN_SCALE_RST;
      octaves_reg <= gnt_pkg::OCTAVE_COUNT_RST;
      fail_count <= 0;
      shade_queue.delete();
      pending_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == gnt_pkg::CFG_PATTERN_SCALE) scale_reg <= cfg_data;
        else if (cfg_index == gnt_pkg::CFG_OCTAVE_COUNT) octaves_reg <= cfg_data[3:0];
      end
      if (in_valid && in_ready) begin
        if (in_payload.action == gnt_pkg::ACT_LOAD) begin
          grad_tab[in_payload.entry_index][0] = in_payload.grad_x;
          grad_tab[in_payload.entry_index][1] = in_payload.grad_y;
          grad_tab[in_payload.entry_index][2] = in_payload.grad_z;
          perm_x_tab[in_payload.entry_index] = in_payload.perm_x_value;
          perm_y_tab[in_payload.entry_index] = in_payload.perm_y_value;
          perm_z_tab[in_payload.entry_index] = in_payload.perm_z_value;
        end else begin
          shade_queue.push_back(marble_sample(in_payload));
        end
      end
      if (out_valid && out_ready) begin
        if (shade_queue.size() == 0) begin
          $error("unexpected result turbulence_value %0d shade_value %0d",
                 out_payload.turbulence_value, out_payload.shade_value);
          errs = errs + 1;
        end else begin
          want = shade_queue.pop_front();
          if (want.turbulence_value !== out_payload.turbulence_value) begin
            $error("turbulence_value expected %0d actual %0d",
                   want.turbulence_value, out_payload.turbulence_value);
            errs = errs + 1;
          end
          if (want.shade_value !== out_payload.shade_value) begin
            $error("shade_value expected %0d actual %0d",
                   want.shade_value, out_payload.shade_value);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending_count <= shade_queue.size();
    end
  end
endmodule

// ----- bench/gradient_noise_turbulence_core_tb.sv -----
// Testbench top for the gradient noise turbulence core: drives requests, register
// writes and result back-pressure, and gives the verdict.
// Depends on gnt_pkg, gnt_stream_if, the core and gnt_turbulence_checker.
module gradient_noise_turbulence_core_tb;

  localparam int DRAIN_CYCLES = 60;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [gnt_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [gnt_pkg::CFG_DATA_W-1:0] cfg_data;
  int fail_count, pending_count;
  int sender_idle_pct, receiver_stall_pct;
  int quiet_cycles;

  gnt_stream_if #(.payload_t(gnt_pkg::in_req_t)) in_ch ();
  gnt_stream_if #(.payload_t(gnt_pkg::out_rsp_t)) out_ch ();

  gradient_noise_turbulence_core DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gnt_turbulence_checker checker_u (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_payload(in_ch.payload),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_payload(out_ch.payload),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (receiver_stall_pct == 0) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** gradient_noise_turbulence_core: FAILED **");
      $finish;
    end
  end

  task automatic push_request(input gnt_pkg::in_req_t r);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= r;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_registers(input logic [23:0] scale, input logic [3:0] octaves);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= gnt_pkg::CFG_PATTERN_SCALE;
    cfg_data <= scale;
    @(posedge clk);
    cfg_index <= gnt_pkg::CFG_OCTAVE_COUNT;
    cfg_data <= {20'd0, octaves};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic gnt_pkg::in_req_t noise_request();
    logic [191:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return noise[$bits(gnt_pkg::in_req_t)-1:0];
  endfunction

  function automatic gnt_pkg::in_req_t load_request(input logic [7:0] idx,
                                                    input logic [15:0] gx,
                                                    input logic [15:0] gy,
                                                    input logic [15:0] gz);
    gnt_pkg::in_req_t r;
    r = noise_request();
    r.action = gnt_pkg::ACT_LOAD;
    r.entry_index = idx;
    r.grad_x = gx;
    r.grad_y = gy;
    r.grad_z = gz;
    r.perm_x_value = 8'($urandom);
    r.perm_y_value = 8'($urandom);
    r.perm_z_value = 8'($urandom);
    return r;
  endfunction

  function automatic gnt_pkg::in_req_t sample_request(input logic [31:0] x,
                                                      input logic [31:0] y,
                                                      input logic [31:0] z);
    gnt_pkg::in_req_t r;
    r = noise_request();
    r.action = gnt_pkg::ACT_SAMPLE;
    r.pos_x = x;
    r.pos_y = y;
    r.pos_z = z;
    return r;
  endfunction

  function automatic logic [15:0] random_gradient();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($urandom_range(32768) - 16384);
  endfunction

  function automatic logic [31:0] random_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($urandom_range(2097152)) - 32'd1048576;
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return 32'($urandom_range(65536)) - 32'd32768;
    endcase
  endfunction

  initial begin
    logic [23:0] scales [8];
    logic [3:0]  octave_set [8];
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= gnt_pkg::CFG_PATTERN_SCALE;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.payload <= '0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 256; i++)
      push_request(load_request(i[7:0], random_gradient(), random_gradient(),
                                random_gradient()));

    push_request(load_request(8'd0, 16'sd16384, 16'sd16384, 16'sd16384));
    push_request(load_request(8'd255, -16'sd16384, -16'sd16384, -16'sd16384));
    push_request(load_request(8'd1, 16'h7FFF, 16'h8000, 16'h0000));
    push_request(sample_request(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    push_request(sample_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    push_request(sample_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    push_request(sample_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    push_request(sample_request(32'h0000_8000, 32'h0000_FFFF, 32'h00FF_0001));
    push_request(sample_request(32'h00FF_8000, 32'hFF00_4000, 32'h8000_C000));
    push_request(sample_request(32'h5555_AAAA, 32'hAAAA_5555, 32'h1234_5678));

    scales = '{24'd65536, 24'd0, 24'hFFFFFF, 24'd1, 24'd200000, 24'd65536, 24'd3000000, 24'd7};
    octave_set = '{4'd7, 4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5, 4'd2};
    for (int ph = 0; ph < 8; ph++) begin
      write_registers(scales[ph] ^ ((ph > 4) ? 24'($urandom) : 24'd0), octave_set[ph]);
      case (ph % 4)
        0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
        1: begin sender_idle_pct = 46; receiver_stall_pct = 0; end
        2: begin sender_idle_pct = 0; receiver_stall_pct = 46; end
        default: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
      endcase
      for (int k = 0; k < 123; k++) begin
        if (k == 61) drain_results();
        if ($urandom_range(4) == 0)
          push_request(load_request(8'($urandom), random_gradient(), random_gradient(),
                                    random_gradient()));
        else
          push_request(sample_request(random_coord(), random_coord(), random_coord()));
      end
    end

    drain_results();
    if (fail_count == 0) $display("** gradient_noise_turbulence_core: PASSED **");
    else $display("** gradient_noise_turbulence_core: FAILED **");
    $finish;
  end
endmodule
